// File: sv/polyline_uniform_resampler_assert.svh
// ----------------------------------------------------------------------------
// polyline_uniform_resampler_assert
// assertion macros shared by the resampler modules
// ----------------------------------------------------------------------------
`ifndef POLYLINE_UNIFORM_RESAMPLER_ASSERT_SVH
`define POLYLINE_UNIFORM_RESAMPLER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PUR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PUR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pur_pkg.sv
// ----------------------------------------------------------------------------
// pur_pkg
// types, constants and command codes of the polyline uniform resampler
// ----------------------------------------------------------------------------
package pur_pkg;

  localparam int unsigned MAX_RUN       = 64;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned RATIO_BITS    = 30;
  localparam int unsigned INTERVAL_W    = 21;
  localparam int unsigned RUN_W         = $clog2(MAX_RUN + 1);

  localparam longint unsigned ONE_METRE = 64'd1 << FRACTION_BITS;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'((ONE_METRE + 5) / 10);
  // shortest segment kept, and closing distance, in length units
  localparam logic [32:0] SKIP_LIMIT  = 33'((ONE_METRE + 999999) / 1000000);
  localparam logic [32:0] CLOSE_LIMIT = 33'(ONE_METRE / 1000);

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               final_vertex;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               run_end;
    logic               dropped_points;
  } out_word_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_FIRST,
    CMD_MAG_SEG,
    CMD_MAG_CLS,
    CMD_SQR,
    CMD_SQRT_INIT,
    CMD_SQRT,
    CMD_NO_SAMPLE,
    CMD_DIVC_INIT,
    CMD_DIVC,
    CMD_COUNT,
    CMD_RAT_INIT,
    CMD_RAT,
    CMD_LX_INIT,
    CMD_LX,
    CMD_LX_DONE,
    CMD_LY_INIT,
    CMD_LY,
    CMD_LY_DONE,
    CMD_PUSH,
    CMD_CLOSE,
    CMD_FLUSH
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FIRST,
    ST_MAG,
    ST_SQR,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_CHECK,
    ST_DIVC_INIT,
    ST_DIVC,
    ST_COUNT,
    ST_RAT_INIT,
    ST_RAT,
    ST_LX_INIT,
    ST_LX,
    ST_LX_DONE,
    ST_LY_INIT,
    ST_LY,
    ST_LY_DONE,
    ST_PUSH,
    ST_CLOSE_CHK,
    ST_CLOSE,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic last;        // iteration counter at zero
    logic skip;        // segment too short
    logic off_le_len;  // a sample falls on the segment
    logic far;         // final vertex away from last point
    logic slot_ok;     // a point may be pushed
    logic open;
    logic fin;
    logic run_last;    // one sample left
  } sts_t;

endpackage

// File: sv/polyline_uniform_resampler.sv
// ----------------------------------------------------------------------------
// polyline_uniform_resampler
// resamples a 2-D polyline into points evenly spaced along its arc length
// ----------------------------------------------------------------------------
//   channel   direction  handshake                word
//   vertex    in         in_valid_i / in_stall_o  pur_pkg::in_word_t
//   point     out        out_valid_o / out_stall_i pur_pkg::out_word_t
//   interval  in         cfg_we_i                 cfg_data_i
//
// first vertex of a path: emitted without the squares; later vertex: squares,
// the 33-step square root and the end, plus the count division and, per
// emitted point, a 31-step ratio division and two products
// a final vertex adds the closing distance, and its point if it is emitted
// reset clears path state and sets the interval to 0.1 m
// a stalled output holds the next point back and pauses the sequencer
// ----------------------------------------------------------------------------
module polyline_uniform_resampler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pur_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pur_pkg::out_word_t             out_word_o,
  input  logic                           cfg_we_i,
  input  logic [pur_pkg::INTERVAL_W-1:0] cfg_data_i
);

  pur_pkg::cmd_e cmd;
  pur_pkg::sts_t sts;

  pur_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pur_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: sv/pur_ctrl.sv
// ----------------------------------------------------------------------------
// pur_ctrl
// sequencer of the resampler: steps the datapath through one vertex
// ----------------------------------------------------------------------------
module pur_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pur_pkg::sts_t    sts_i,
  output pur_pkg::cmd_e    cmd_o
);

  pur_pkg::state_e state_q, state_d;
  logic            cls_q, cls_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pur_pkg::ST_IDLE;
      cls_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cls_d      = cls_q;
    cmd_o      = pur_pkg::CMD_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      pur_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o   = pur_pkg::CMD_LOAD;
          cls_d   = 1'b0;
          state_d = pur_pkg::ST_MAG;
        end
      end
      pur_pkg::ST_MAG: begin
        if (!sts_i.open) begin
          state_d = pur_pkg::ST_FIRST;
        end else begin
          cmd_o   = cls_q ? pur_pkg::CMD_MAG_CLS : pur_pkg::CMD_MAG_SEG;
          state_d = pur_pkg::ST_SQR;
        end
      end
      pur_pkg::ST_FIRST: begin
        if (sts_i.slot_ok) begin
          cmd_o   = pur_pkg::CMD_FIRST;
          state_d = pur_pkg::ST_FLUSH;
        end
      end
      pur_pkg::ST_SQR: begin
        cmd_o = pur_pkg::CMD_SQR;
        if (sts_i.last) state_d = pur_pkg::ST_SQRT_INIT;
      end
      pur_pkg::ST_SQRT_INIT: begin
        cmd_o   = pur_pkg::CMD_SQRT_INIT;
        state_d = pur_pkg::ST_SQRT;
      end
      pur_pkg::ST_SQRT: begin
        cmd_o = pur_pkg::CMD_SQRT;
        if (sts_i.last) state_d = cls_q ? pur_pkg::ST_CLOSE_CHK : pur_pkg::ST_CHECK;
      end
      pur_pkg::ST_CHECK: begin
        if (!sts_i.skip && sts_i.off_le_len) begin
          state_d = pur_pkg::ST_DIVC_INIT;
        end else begin
          if (!sts_i.skip) cmd_o = pur_pkg::CMD_NO_SAMPLE;
          cls_d   = sts_i.fin;
          state_d = sts_i.fin ? pur_pkg::ST_MAG : pur_pkg::ST_FLUSH;
        end
      end
      pur_pkg::ST_DIVC_INIT: begin
        cmd_o   = pur_pkg::CMD_DIVC_INIT;
        state_d = pur_pkg::ST_DIVC;
      end
      pur_pkg::ST_DIVC: begin
        cmd_o = pur_pkg::CMD_DIVC;
        if (sts_i.last) state_d = pur_pkg::ST_COUNT;
      end
      pur_pkg::ST_COUNT: begin
        cmd_o   = pur_pkg::CMD_COUNT;
        state_d = pur_pkg::ST_RAT_INIT;
      end
      pur_pkg::ST_RAT_INIT: begin
        cmd_o   = pur_pkg::CMD_RAT_INIT;
        state_d = pur_pkg::ST_RAT;
      end
      pur_pkg::ST_RAT: begin
        cmd_o = pur_pkg::CMD_RAT;
        if (sts_i.last) state_d = pur_pkg::ST_LX_INIT;
      end
      pur_pkg::ST_LX_INIT: begin
        cmd_o   = pur_pkg::CMD_LX_INIT;
        state_d = pur_pkg::ST_LX;
      end
      pur_pkg::ST_LX: begin
        cmd_o = pur_pkg::CMD_LX;
        if (sts_i.last) state_d = pur_pkg::ST_LX_DONE;
      end
      pur_pkg::ST_LX_DONE: begin
        cmd_o   = pur_pkg::CMD_LX_DONE;
        state_d = pur_pkg::ST_LY_INIT;
      end
      pur_pkg::ST_LY_INIT: begin
        cmd_o   = pur_pkg::CMD_LY_INIT;
        state_d = pur_pkg::ST_LY;
      end
      pur_pkg::ST_LY: begin
        cmd_o = pur_pkg::CMD_LY;
        if (sts_i.last) state_d = pur_pkg::ST_LY_DONE;
      end
      pur_pkg::ST_LY_DONE: begin
        cmd_o   = pur_pkg::CMD_LY_DONE;
        state_d = pur_pkg::ST_PUSH;
      end
      pur_pkg::ST_PUSH: begin
        if (sts_i.slot_ok) begin
          cmd_o = pur_pkg::CMD_PUSH;
          if (sts_i.run_last) begin
            cls_d   = sts_i.fin;
            state_d = sts_i.fin ? pur_pkg::ST_MAG : pur_pkg::ST_FLUSH;
          end else begin
            state_d = pur_pkg::ST_RAT_INIT;
          end
        end
      end
      pur_pkg::ST_CLOSE_CHK: begin
        state_d = sts_i.far ? pur_pkg::ST_CLOSE : pur_pkg::ST_FLUSH;
      end
      pur_pkg::ST_CLOSE: begin
        if (sts_i.slot_ok) begin
          cmd_o   = pur_pkg::CMD_CLOSE;
          state_d = pur_pkg::ST_FLUSH;
        end
      end
      pur_pkg::ST_FLUSH: begin
        if (sts_i.slot_ok) begin
          cmd_o   = pur_pkg::CMD_FLUSH;
          state_d = pur_pkg::ST_IDLE;
        end
      end
      default: state_d = pur_pkg::ST_IDLE;
    endcase
  end

`include "polyline_uniform_resampler_assert.svh"

  `PUR_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != pur_pkg::ST_IDLE, "vertex taken but controller stayed idle")
  `PUR_ASSERT_NOW(a_push_needs_slot, cmd_o == pur_pkg::CMD_PUSH || cmd_o == pur_pkg::CMD_FLUSH, sts_i.slot_ok, "point pushed with no free slot")
  `PUR_ASSERT_NOW(a_busy_stalls, state_q != pur_pkg::ST_IDLE, in_stall_o, "vertex input open while busy")

endmodule

// File: sv/pur_dpath.sv
// ----------------------------------------------------------------------------
// pur_dpath
// resampler datapath: squares, square root, dividers, interpolation, output
// ----------------------------------------------------------------------------
module pur_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pur_pkg::cmd_e                      cmd_i,
  output pur_pkg::sts_t                      sts_o,
  input  pur_pkg::in_word_t                  in_word_i,
  input  logic                               cfg_we_i,
  input  logic [pur_pkg::INTERVAL_W-1:0]     cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pur_pkg::out_word_t                 out_word_o
);

  localparam int unsigned IW = pur_pkg::INTERVAL_W;
  localparam int unsigned RB = pur_pkg::RATIO_BITS;

  logic [IW-1:0]        int_q, iv;
  logic signed [31:0]   vx_q, vy_q, prev_x_q, prev_y_q, emit_x_q, emit_y_q;
  logic signed [31:0]   px_q, py_q, pend_x_q, pend_y_q;
  logic                 fin_q, open_q, drop_q, pend_v_q, out_valid_q;
  logic [IW-1:0]        off_q;
  logic [33:0]          t_q;
  logic [pur_pkg::RUN_W-1:0] nsamp_q;
  logic [5:0]           cnt_q;
  logic [32:0]          ax_q, ay_q;
  logic                 sx_q, sy_q;
  logic [65:0]          acc_q;
  logic [34:0]          srem_q;
  logic [32:0]          root_q;
  logic [32:0]          dq_q;
  logic [33:0]          drem_q;
  pur_pkg::out_word_t   out_q;

  logic signed [31:0]   ox, oy, lerp_base, lerp_res;
  logic signed [32:0]   dxs, dys;
  logic [32:0]          mul_a;
  logic [16:0]          mul_b;
  logic                 mul_sh;
  logic [49:0]          prod;
  logic [65:0]          prod_ext;
  logic [36:0]          s_cur, s_trial;
  logic [33:0]          c_cur;
  logic                 c_ge, r_ge, lerp_neg;
  logic [33:0]          r_diff;
  logic [pur_pkg::RUN_W-1:0] cap;
  logic [31:0]          q32;
  logic                 slot_free, out_load;

  assign iv = (int_q == '0) ? IW'(1) : int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q <= pur_pkg::INTERVAL_RESET;
    end else if (cfg_we_i) begin
      int_q <= cfg_data_i;
    end
  end

  // segment or closing distance operands
  assign ox  = (cmd_i == pur_pkg::CMD_MAG_CLS) ? emit_x_q : prev_x_q;
  assign oy  = (cmd_i == pur_pkg::CMD_MAG_CLS) ? emit_y_q : prev_y_q;
  assign dxs = {vx_q[31], vx_q} - {ox[31], ox};
  assign dys = {vy_q[31], vy_q} - {oy[31], oy};

  // shared 33x17 multiplier
  always_comb begin
    mul_a  = ax_q;
    mul_b  = ax_q[16:0];
    mul_sh = 1'b0;
    case (cmd_i)
      pur_pkg::CMD_SQR: begin
        mul_a  = cnt_q[1] ? ax_q : ay_q;
        mul_sh = ~cnt_q[0];
        if (cnt_q[1]) mul_b = cnt_q[0] ? ax_q[16:0] : {1'b0, ax_q[32:17]};
        else          mul_b = cnt_q[0] ? ay_q[16:0] : {1'b0, ay_q[32:17]};
      end
      pur_pkg::CMD_LX, pur_pkg::CMD_LY: begin
        mul_a  = (cmd_i == pur_pkg::CMD_LX) ? ax_q : ay_q;
        mul_sh = ~cnt_q[0];
        mul_b  = cnt_q[0] ? dq_q[16:0] : {3'b0, dq_q[30:17]};
      end
      default: mul_b = ax_q[16:0];
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = mul_sh ? {prod[48:0], 17'b0} : {16'b0, prod};

  // square root digit step
  assign s_cur   = {srem_q, acc_q[65:64]};
  assign s_trial = {2'b0, root_q, 2'b01};

  // count divider step
  assign c_cur = {drem_q[32:0], dq_q[32]};
  assign c_ge  = c_cur >= {13'b0, iv};

  // ratio divider step
  assign r_ge   = drem_q >= {1'b0, root_q};
  assign r_diff = drem_q - {1'b0, root_q};

  assign cap = fin_q ? pur_pkg::RUN_W'(pur_pkg::MAX_RUN - 1) : pur_pkg::RUN_W'(pur_pkg::MAX_RUN);

  // interpolation result
  assign q32       = acc_q[RB+31:RB];
  assign lerp_neg  = (cmd_i == pur_pkg::CMD_LX_DONE) ? sx_q : sy_q;
  assign lerp_base = (cmd_i == pur_pkg::CMD_LX_DONE) ? prev_x_q : prev_y_q;
  assign lerp_res  = lerp_neg ? lerp_base - $signed(q32) : lerp_base + $signed(q32);

  assign slot_free = !out_valid_q || !out_stall_i;
  assign out_load  = pend_v_q && (cmd_i == pur_pkg::CMD_FIRST || cmd_i == pur_pkg::CMD_PUSH ||
                     cmd_i == pur_pkg::CMD_CLOSE || cmd_i == pur_pkg::CMD_FLUSH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      emit_x_q    <= '0;
      emit_y_q    <= '0;
      off_q       <= pur_pkg::INTERVAL_RESET;
      open_q      <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      drop_q      <= 1'b0;
      cnt_q       <= '0;
      nsamp_q     <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cnt_q != '0 && (cmd_i == pur_pkg::CMD_SQR || cmd_i == pur_pkg::CMD_SQRT ||
          cmd_i == pur_pkg::CMD_DIVC || cmd_i == pur_pkg::CMD_RAT ||
          cmd_i == pur_pkg::CMD_LX || cmd_i == pur_pkg::CMD_LY)) begin
        cnt_q <= cnt_q - 6'd1;
      end
      case (cmd_i)
        pur_pkg::CMD_LOAD: drop_q <= 1'b0;
        pur_pkg::CMD_FIRST: begin
          off_q    <= iv;
          open_q   <= 1'b1;
          emit_x_q <= vx_q;
          emit_y_q <= vy_q;
          pend_v_q <= 1'b1;
        end
        pur_pkg::CMD_MAG_SEG, pur_pkg::CMD_MAG_CLS: cnt_q <= 6'd3;
        pur_pkg::CMD_SQRT_INIT: cnt_q <= 6'd32;
        pur_pkg::CMD_NO_SAMPLE: off_q <= off_q - root_q[IW-1:0];
        pur_pkg::CMD_DIVC_INIT: cnt_q <= 6'd32;
        pur_pkg::CMD_COUNT: begin
          off_q <= iv - drem_q[IW-1:0];
          if (dq_q >= 33'(cap)) begin
            nsamp_q <= cap;
            drop_q  <= 1'b1;
          end else begin
            nsamp_q <= pur_pkg::RUN_W'(dq_q) + pur_pkg::RUN_W'(1);
          end
        end
        pur_pkg::CMD_RAT_INIT: cnt_q <= 6'(RB);
        pur_pkg::CMD_LX_INIT, pur_pkg::CMD_LY_INIT: cnt_q <= 6'd1;
        pur_pkg::CMD_PUSH: begin
          nsamp_q  <= nsamp_q - pur_pkg::RUN_W'(1);
          emit_x_q <= px_q;
          emit_y_q <= py_q;
          pend_v_q <= 1'b1;
        end
        pur_pkg::CMD_CLOSE: begin
          emit_x_q <= vx_q;
          emit_y_q <= vy_q;
          pend_v_q <= 1'b1;
        end
        pur_pkg::CMD_FLUSH: begin
          pend_v_q <= 1'b0;
          prev_x_q <= vx_q;
          prev_y_q <= vy_q;
          if (fin_q) open_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload and datapath registers (no reset)
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.point_x        <= pend_x_q;
      out_q.point_y        <= pend_y_q;
      out_q.run_end        <= (cmd_i == pur_pkg::CMD_FLUSH);
      out_q.dropped_points <= drop_q;
    end
    case (cmd_i)
      pur_pkg::CMD_LOAD: begin
        vx_q  <= in_word_i.vertex_x;
        vy_q  <= in_word_i.vertex_y;
        fin_q <= in_word_i.final_vertex;
      end
      pur_pkg::CMD_FIRST, pur_pkg::CMD_CLOSE: begin
        pend_x_q <= vx_q;
        pend_y_q <= vy_q;
      end
      pur_pkg::CMD_PUSH: begin
        pend_x_q <= px_q;
        pend_y_q <= py_q;
        t_q      <= t_q + {13'b0, iv};
      end
      pur_pkg::CMD_MAG_SEG, pur_pkg::CMD_MAG_CLS: begin
        ax_q  <= dxs[32] ? 33'(-dxs) : 33'(dxs);
        ay_q  <= dys[32] ? 33'(-dys) : 33'(dys);
        sx_q  <= dxs[32];
        sy_q  <= dys[32];
        acc_q <= '0;
      end
      pur_pkg::CMD_SQR, pur_pkg::CMD_LX, pur_pkg::CMD_LY: acc_q <= acc_q + prod_ext;
      pur_pkg::CMD_SQRT_INIT: begin
        srem_q <= '0;
        root_q <= '0;
      end
      pur_pkg::CMD_SQRT: begin
        if (s_cur >= s_trial) begin
          srem_q <= 35'(s_cur - s_trial);
          root_q <= {root_q[31:0], 1'b1};
        end else begin
          srem_q <= s_cur[34:0];
          root_q <= {root_q[31:0], 1'b0};
        end
        acc_q <= {acc_q[63:0], 2'b00};
      end
      pur_pkg::CMD_DIVC_INIT: begin
        dq_q   <= root_q - {12'b0, off_q};
        drem_q <= '0;
      end
      pur_pkg::CMD_DIVC: begin
        drem_q <= c_ge ? c_cur - {13'b0, iv} : c_cur;
        dq_q   <= {dq_q[31:0], c_ge};
      end
      pur_pkg::CMD_COUNT: t_q <= {13'b0, off_q};
      pur_pkg::CMD_RAT_INIT: begin
        drem_q <= t_q;
        dq_q   <= '0;
      end
      pur_pkg::CMD_RAT: begin
        drem_q <= r_ge ? {r_diff[32:0], 1'b0} : {drem_q[32:0], 1'b0};
        dq_q   <= {dq_q[31:0], r_ge};
      end
      pur_pkg::CMD_LX_INIT, pur_pkg::CMD_LY_INIT: acc_q <= 66'(64'd1 << (RB - 1));
      pur_pkg::CMD_LX_DONE: px_q <= lerp_res;
      pur_pkg::CMD_LY_DONE: py_q <= lerp_res;
      default: ;
    endcase
  end

  always_comb begin
    sts_o.last       = (cnt_q == '0);
    sts_o.skip       = root_q < pur_pkg::SKIP_LIMIT;
    sts_o.off_le_len = {12'b0, off_q} <= root_q;
    sts_o.far        = root_q > pur_pkg::CLOSE_LIMIT;
    sts_o.slot_ok    = !pend_v_q || slot_free;
    sts_o.open       = open_q;
    sts_o.fin        = fin_q;
    sts_o.run_last   = (nsamp_q == pur_pkg::RUN_W'(1));
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`include "polyline_uniform_resampler_assert.svh"

  `PUR_ASSERT_NOW(a_run_bounded, 1'b1, nsamp_q <= pur_pkg::RUN_W'(pur_pkg::MAX_RUN), "sample run above limit")
  `PUR_ASSERT_NEXT(a_count_nonzero, cmd_i == pur_pkg::CMD_COUNT, nsamp_q != '0, "segment with sample gave empty run")
  `PUR_ASSERT_NEXT(a_flush_empties, cmd_i == pur_pkg::CMD_FLUSH, !pend_v_q, "pending point left after vertex end")

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the polyline resampler against its own predictor, random flow control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pur_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pur_pkg::out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [pur_pkg::INTERVAL_W-1:0] cfg_data_i = '0;

  polyline_uniform_resampler u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state
  logic [31:0] interval_q;
  logic signed [31:0] prev_x, prev_y, emit_x, emit_y;
  logic [31:0] pending_off;
  bit path_live;

  pur_pkg::in_word_t  vertex_queue[$];
  pur_pkg::out_word_t point_queue[$];
  int unsigned mismatches, points_seen, cycles;
  bit gaps_on, hold_sender;

  function automatic longint unsigned dist_floor(logic signed [31:0] x0, logic signed [31:0] y0,
                                                 logic signed [31:0] x1, logic signed [31:0] y1);
    longint signed dx, dy;
    logic [65:0] sq, cand;
    logic [32:0] root;
    dx = longint'(x1) - longint'(x0);
    dy = longint'(y1) - longint'(y0);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      cand = 66'(root | (33'd1 << b));
      if (cand * cand <= sq) root = root | (33'd1 << b);
    end
    return 64'(root);
  endfunction

  function automatic logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                               longint unsigned ratio);
    longint signed d;
    logic [95:0] q;
    d = longint'(b) - longint'(a);
    q = (96'(d < 0 ? -d : d) * 96'(ratio) + (96'd1 << (pur_pkg::RATIO_BITS - 1)))
        >> pur_pkg::RATIO_BITS;
    return d < 0 ? 32'(longint'(a) - longint'(q)) : 32'(longint'(a) + longint'(q));
  endfunction

  task automatic predict_points(pur_pkg::in_word_t w);
    pur_pkg::out_word_t pts[$];
    pur_pkg::out_word_t p;
    longint unsigned iv, len, off, cnt, nxt, cap, span, t, ratio;
    bit dropped;
    dropped = 0;
    iv = interval_q == 0 ? 1 : interval_q;
    if (!path_live) begin
      p = '0; p.point_x = w.vertex_x; p.point_y = w.vertex_y;
      pts = {pts, p};
      pending_off = 32'(iv);
      path_live = 1;
    end else begin
      len = dist_floor(prev_x, prev_y, w.vertex_x, w.vertex_y);
      if (!(len * 1000000 < pur_pkg::ONE_METRE)) begin
        off = pending_off;
        cap = w.final_vertex ? pur_pkg::MAX_RUN - 1 : pur_pkg::MAX_RUN;
        if (off <= len) begin
          span = len - off;
          cnt = span / iv + 1;
          nxt = iv - span % iv;
        end else begin
          cnt = 0;
          nxt = off - len;
        end
        if (cnt > cap) begin
          cnt = cap;
          dropped = 1;
        end
        for (longint unsigned i = 0; i < cnt; i++) begin
          t = off + i * iv;
          ratio = 64'((96'(t) << pur_pkg::RATIO_BITS) / 96'(len));
          p = '0;
          p.point_x = blend(prev_x, w.vertex_x, ratio);
          p.point_y = blend(prev_y, w.vertex_y, ratio);
          emit_x = p.point_x; emit_y = p.point_y;
          pts = {pts, p};
        end
        pending_off = 32'(nxt);
      end
      if (w.final_vertex &&
          dist_floor(emit_x, emit_y, w.vertex_x, w.vertex_y) * 1000 > pur_pkg::ONE_METRE) begin
        p = '0; p.point_x = w.vertex_x; p.point_y = w.vertex_y;
        pts = {pts, p};
      end
    end
    prev_x = w.vertex_x; prev_y = w.vertex_y;
    if (pts.size() > 0) begin
      emit_x = pts[$].point_x; emit_y = pts[$].point_y;
    end
    if (w.final_vertex) path_live = 0;
    foreach (pts[k]) begin
      pts[k].run_end = (k == pts.size() - 1);
      pts[k].dropped_points = dropped;
      point_queue = {point_queue, pts[k]};
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      predict_points(in_word_i);
    end
    if (!in_valid_i || !in_stall_o) begin
      if (vertex_queue.size() > 0 && !hold_sender &&
          !(gaps_on && $urandom_range(99) < 19)) begin
        in_word_i <= vertex_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pur_pkg::out_word_t exp_w;
    cycles <= cycles + 1;
    if (out_valid_o && !out_stall_i) begin
      points_seen <= points_seen + 1;
      if (point_queue.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected point %p", out_word_o);
      end else begin
        exp_w = point_queue.pop_front();
        if (exp_w !== out_word_o) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("point mismatch: expected %p, got %p", exp_w, out_word_o);
        end
      end
    end
    out_stall_i <= gaps_on && ($urandom_range(99) < 19);
  end

  initial begin
    if (1) begin
      forever begin
        @(posedge clk_i);
        if (cycles > 10000000) begin
          $display("timeout");
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  function automatic pur_pkg::in_word_t vtx(int x, int y, bit f);
    pur_pkg::in_word_t w;
    w.vertex_x = x; w.vertex_y = y; w.final_vertex = f;
    return w;
  endfunction

  function automatic void queue_vertex(int x, int y, bit f);
    vertex_queue = {vertex_queue, vtx(x, y, f)};
  endfunction

  task automatic drain_all();
    while (vertex_queue.size() > 0 || in_valid_i || point_queue.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic set_interval(logic [pur_pkg::INTERVAL_W-1:0] v);
    drain_all();
    @(posedge clk_i);
    cfg_data_i <= v;
    cfg_we_i <= 1'b1;
    interval_q = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_paths(int n_items, int spread);
    int x, y, len;
    while (n_items > 0) begin
      len = $urandom_range(1, 8);
      x = $urandom; y = $urandom;
      if ($urandom_range(3) != 0) begin
        x = $signed(x) >>> 8; y = $signed(y) >>> 8;
      end
      for (int i = 0; i < len && n_items > 0; i++) begin
        if (i > 0) begin
          x = x + $signed($urandom_range(0, 2 * spread)) - spread;
          y = y + $signed($urandom_range(0, 2 * spread)) - spread;
          if ($urandom_range(9) == 0) begin x = $urandom; y = $urandom; end
          if ($urandom_range(15) == 0) begin x = x + $urandom_range(0, 1); end
        end
        queue_vertex(x, y, i == len - 1 || $urandom_range(19) == 0);
        n_items--;
      end
    end
  endtask

  initial begin
    mismatches = 0; points_seen = 0; cycles = 0;
    gaps_on = 1; hold_sender = 0;
    interval_q = pur_pkg::INTERVAL_RESET;
    prev_x = 0; prev_y = 0; emit_x = 0; emit_y = 0;
    pending_off = pur_pkg::INTERVAL_RESET; path_live = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single vertex, extremes, skips, closing, overflow
    queue_vertex(32'sh7fffffff, 32'sh80000000, 1);
    queue_vertex(0, 0, 0);
    queue_vertex(0, 0, 0);
    queue_vertex(1, 0, 0);
    queue_vertex(65536, 0, 0);
    queue_vertex(65536, 65536, 0);
    queue_vertex(65536 + 30, 65536, 1);
    queue_vertex(0, 0, 0);
    queue_vertex(-10 * 65536, 0, 0);
    queue_vertex(-10 * 65536, 7 * 65536, 1);
    queue_vertex(32'sh80000000, 32'sh80000000, 0);
    queue_vertex(32'sh7fffffff, 32'sh7fffffff, 1);
    queue_vertex(-5, -5, 0);
    queue_vertex(6549, -5, 1);

    // sender pauses until every point is back
    drain_all();
    hold_sender = 1;
    queue_vertex(100, 200, 0);
    queue_vertex(300000, -400000, 1);
    hold_sender = 0;

    set_interval(21'd0);
    queue_vertex(0, 0, 0);
    queue_vertex(40, 0, 1);
    set_interval(21'd66);
    random_paths(60, 4000);
    set_interval(21'h1fffff);
    random_paths(60, 32'h00400000);
    set_interval(21'd1048576);
    random_paths(80, 32'h00100000);
    gaps_on = 0;
    set_interval(pur_pkg::INTERVAL_RESET);
    random_paths(120, 300000);
    gaps_on = 1;
    set_interval(21'($urandom_range(66, 1048576)));
    random_paths(160, 500000);
    drain_all();

    $display("vertices driven through intervals from zero to full scale, %0d points checked",
             points_seen);
    if (mismatches == 0 && point_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
